### sv/x86_64_add_encoder_core_assert.svh
// assertion macros shared by the encoder rtl
`ifndef X86_64_ADD_ENCODER_CORE_ASSERT_SVH
`define X86_64_ADD_ENCODER_CORE_ASSERT_SVH

// condition must hold at every clock edge outside reset
`define X64AE_ASSERT_NOW(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// consequent must hold in the cycle after the antecedent
`define X64AE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### sv/x64ae_pkg.sv
// types and encoding constants for the x86-64 add encoder
package x64ae_pkg;

	// operand forms
	localparam logic [2:0] ACT_REG_REG = 3'd0;
	localparam logic [2:0] ACT_REG_MEM = 3'd1;
	localparam logic [2:0] ACT_MEM_REG = 3'd2;
	localparam logic [2:0] ACT_REG_IMM = 3'd3;
	localparam logic [2:0] ACT_MEM_IMM = 3'd4;

	// instruction bytes
	localparam logic [7:0] REX_W        = 8'h48;
	localparam logic [7:0] REX_R        = 8'h04;
	localparam logic [7:0] REX_B        = 8'h01;
	localparam logic [7:0] OP_RM_R      = 8'h01;
	localparam logic [7:0] OP_R_RM      = 8'h03;
	localparam logic [7:0] OP_IMM8      = 8'h83;
	localparam logic [7:0] OP_IMM32     = 8'h81;
	localparam logic [7:0] MODRM_DIRECT = 8'hC0;
	localparam logic [7:0] SIB_NO_INDEX = 8'h24;

	// modrm mod field values
	localparam logic [1:0] MOD_NODISP = 2'd0;
	localparam logic [1:0] MOD_DISP8  = 2'd1;
	localparam logic [1:0] MOD_DISP32 = 2'd2;

	// register numbers whose low bits need special handling
	localparam logic [2:0] RM_SIB  = 3'd4;
	localparam logic [2:0] RM_BP   = 3'd5;

	localparam int MAX_BYTES = 12;
	localparam int LEN_W     = 4;

	typedef struct packed {
		logic [2:0]         action;
		logic [3:0]         dest_reg;
		logic [3:0]         source_reg;
		logic [3:0]         base_reg;
		logic signed [31:0] displacement;
		logic signed [31:0] immediate;
	} in_item_t;

	typedef struct packed {
		logic [7:0] code_byte;
		logic       last;
	} out_item_t;

	// one fully encoded instruction, byte 0 goes out first
	typedef struct packed {
		logic [MAX_BYTES-1:0][7:0] bytes;
		logic [LEN_W-1:0]          len;
	} enc_t;

	// true when a 32-bit value is representable as a sign-extended byte
	function automatic logic fits_s8(input logic [31:0] v);
		fits_s8 = (&v[31:7]) | ~(|v[31:7]);
	endfunction

endpackage

### sv/x64ae_encode.sv
// combinational encoder: one add request to its instruction bytes and length
module x64ae_encode import x64ae_pkg::*; (
	input  in_item_t req,
	output enc_t     enc
);

	logic             mem_form;
	logic             imm_form;
	logic             imm_small;
	logic             disp_small;
	logic [3:0]       reg_r;
	logic [3:0]       reg_b;
	logic [2:0]       modrm_reg;
	logic [1:0]       mod;
	logic [2:0]       disp_len;
	logic [2:0]       imm_len;
	logic [7:0]       opcode;
	logic [7:0]       rex;
	logic [7:0]       modrm;
	logic [LEN_W-1:0] pos;

	// operand roles per form
	always_comb begin
		mem_form  = 1'b0;
		imm_form  = 1'b0;
		reg_r     = 4'd0;
		reg_b     = 4'd0;
		opcode    = OP_RM_R;
		imm_small = fits_s8(req.immediate);
		case (req.action)
			ACT_REG_REG: begin
				reg_r  = req.source_reg;
				reg_b  = req.dest_reg;
			end
			ACT_REG_MEM: begin
				mem_form = 1'b1;
				reg_r    = req.dest_reg;
				reg_b    = req.base_reg;
				opcode   = OP_R_RM;
			end
			ACT_MEM_REG: begin
				mem_form = 1'b1;
				reg_r    = req.source_reg;
				reg_b    = req.base_reg;
			end
			ACT_REG_IMM: begin
				imm_form = 1'b1;
				reg_b    = req.dest_reg;
				opcode   = imm_small ? OP_IMM8 : OP_IMM32;
			end
			ACT_MEM_IMM: begin
				mem_form = 1'b1;
				imm_form = 1'b1;
				reg_b    = req.base_reg;
				opcode   = imm_small ? OP_IMM8 : OP_IMM32;
			end
			default: begin
				reg_r = 4'd0;
			end
		endcase
		modrm_reg = reg_r[2:0];
	end

	// addressing mode: rbp/r13 base always carries a displacement
	always_comb begin
		disp_small = fits_s8(req.displacement);
		if (!mem_form) begin
			mod      = MOD_NODISP;
			disp_len = 3'd0;
		end else if (req.displacement == 32'sd0 && reg_b[2:0] != RM_BP) begin
			mod      = MOD_NODISP;
			disp_len = 3'd0;
		end else if (disp_small) begin
			mod      = MOD_DISP8;
			disp_len = 3'd1;
		end else begin
			mod      = MOD_DISP32;
			disp_len = 3'd4;
		end
		if (!imm_form)
			imm_len = 3'd0;
		else if (imm_small)
			imm_len = 3'd1;
		else
			imm_len = 3'd4;
	end

	// prefix and modrm
	always_comb begin
		rex = REX_W | (reg_r[3] ? REX_R : 8'h00) | (reg_b[3] ? REX_B : 8'h00);
		if (mem_form)
			modrm = {mod, modrm_reg, reg_b[2:0]};
		else
			modrm = MODRM_DIRECT | {2'b00, modrm_reg, reg_b[2:0]};
	end

	// byte placement, displacement and immediate little-endian
	always_comb begin
		enc.bytes    = '0;
		enc.bytes[0] = rex;
		enc.bytes[1] = opcode;
		enc.bytes[2] = modrm;
		pos          = LEN_W'(3);
		if (mem_form && reg_b[2:0] == RM_SIB) begin
			enc.bytes[pos] = SIB_NO_INDEX;
			pos            = pos + LEN_W'(1);
		end
		for (int k = 0; k < 4; k++) begin
			if (3'(k) < disp_len)
				enc.bytes[LEN_W'(pos + LEN_W'(k))] = req.displacement[8*k +: 8];
		end
		pos = pos + LEN_W'(disp_len);
		for (int k = 0; k < 4; k++) begin
			if (3'(k) < imm_len)
				enc.bytes[LEN_W'(pos + LEN_W'(k))] = req.immediate[8*k +: 8];
		end
		pos = pos + LEN_W'(imm_len);
		if (req.action > ACT_MEM_IMM)
			enc.len = '0;
		else
			enc.len = pos;
	end

endmodule

### sv/x64ae_serial.sv
// result register: holds an encoded instruction and shifts it out a byte a cycle
`include "x86_64_add_encoder_core_assert.svh"
module x64ae_serial import x64ae_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      load,
	input  enc_t      enc,
	output logic      free,
	output logic      strobe,
	output out_item_t result
);

	logic [MAX_BYTES-1:0][7:0] buf_q;
	logic [LEN_W-1:0]          rem_q;

	// can take a new instruction once at most the final byte is left
	assign free = (rem_q <= LEN_W'(1));

	// remaining byte count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= '0;
		end else if (load) begin
			rem_q <= enc.len;
		end else if (rem_q != '0) begin
			rem_q <= rem_q - LEN_W'(1);
		end
	end

	// byte shift register
	always_ff @(posedge clk) begin
		if (load) begin
			buf_q <= enc.bytes;
		end else begin
			buf_q <= {8'h00, buf_q[MAX_BYTES-1:1]};
		end
	end

	// result transaction
	assign strobe           = (rem_q != '0);
	assign result.code_byte = buf_q[0];
	assign result.last      = (rem_q == LEN_W'(1));

	`X64AE_ASSERT_NOW(a_rem_range, clk, arst_n, rem_q <= LEN_W'(MAX_BYTES), "byte count overflow")
	`X64AE_ASSERT_NOW(a_load_free, clk, arst_n, !load || free, "load over pending bytes")
	`X64AE_ASSERT_NEXT(a_rem_count, clk, arst_n, rem_q > LEN_W'(1),
		rem_q == $past(rem_q) - LEN_W'(1), "byte count skipped")

endmodule

### sv/x86_64_add_encoder_core.sv
// x86-64 add encoder: request register, encoder and byte shift-out
// an accepted request passes the request register and then the byte shift register,
//   which gives its bytes one per cycle; an instruction is 3 to 12 bytes long;
//   one with an undefined form gives no bytes
// the byte shift register sets the rate; a request is taken while the last byte leaves
// reset clears the request valid flag and the byte count; no bytes after reset
`include "x86_64_add_encoder_core_assert.svh"
module x86_64_add_encoder_core import x64ae_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	output logic      busy,
	input  in_item_t  req,
	output logic      strobe,
	output out_item_t result
);

	in_item_t req_s1;
	logic     valid_s1;
	logic     accept;
	logic     move;
	logic     free;
	enc_t     enc;

	// handshake
	assign move   = valid_s1 && free;
	assign busy   = valid_s1 && !free;
	assign accept = start && !busy;

	// request register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (move) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1 <= req;
		end
	end

	// encoding
	x64ae_encode u_encode (
		.req (req_s1),
		.enc (enc)
	);

	// shift-out
	x64ae_serial u_serial (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (move),
		.enc    (enc),
		.free   (free),
		.strobe (strobe),
		.result (result)
	);

	`X64AE_ASSERT_NOW(a_busy_valid, clk, arst_n, !busy || valid_s1, "busy without request")
	`X64AE_ASSERT_NOW(a_last_strobe, clk, arst_n, !result.last || strobe, "last without strobe")
	`X64AE_ASSERT_NEXT(a_bytes_run, clk, arst_n, strobe && !result.last, strobe,
		"gap inside instruction")

endmodule
